### sv/crfe_pkg.sv
package crfe_pkg;

  // Default screen geometry.
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;

  // Field widths of the item channels.
  localparam int ACTION_W = 2;
  localparam int SCOORD_W = 11;
  localparam int SPAN_W   = 10;
  localparam int COLOR_W  = 8;
  localparam int RADDR_W  = 16;

  // Clipped coordinates fit in 10 bits because neither screen dimension exceeds 1024.
  localparam int XY_W   = 10;
  // Unclipped rectangle edges run from -1024 to 2046.
  localparam int EDGE_W = 12;

  // Command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_OUTLINE = 2'd2,
    ACT_READ    = 2'd3
  } crfe_action_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_BOX,
    CMD_READ
  } crfe_cmd_kind_t;

  typedef enum logic [1:0] {
    EDGE_TOP,
    EDGE_BOTTOM,
    EDGE_LEFT,
    EDGE_RIGHT
  } crfe_edge_t;

  // One unit of back-end work. resp marks the command that finishes an item.
  typedef struct packed {
    crfe_cmd_kind_t       kind;
    logic                 resp;
    logic [XY_W-1:0]      x0;
    logic [XY_W-1:0]      x1;
    logic [XY_W-1:0]      y0;
    logic [XY_W-1:0]      y1;
    logic [COLOR_W-1:0]   color;
    logic [RADDR_W-1:0]   addr;
  } crfe_cmd_t;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } crfe_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLEAR,
    B_BOX,
    B_RDATA,
    B_DONE
  } crfe_back_state_t;

endpackage

### sv/crfe_if.sv
interface crfe_in_if;
  import crfe_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [SCOORD_W-1:0] left_x;
  logic signed [SCOORD_W-1:0] top_y;
  logic [SPAN_W-1:0]          rect_width;
  logic [SPAN_W-1:0]          rect_height;
  logic [COLOR_W-1:0]         pixel_color;
  logic [RADDR_W-1:0]         read_address;

  modport source (
    output valid, action, left_x, top_y, rect_width, rect_height, pixel_color, read_address,
    input  ready
  );

  modport sink (
    input  valid, action, left_x, top_y, rect_width, rect_height, pixel_color, read_address,
    output ready
  );
endinterface

interface crfe_out_if;
  import crfe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;

  modport source (
    output valid, read_color,
    input  ready
  );

  modport sink (
    input  valid, read_color,
    output ready
  );
endinterface

### sv/clipped_rectangle_fill_engine.sv
// Channel   Direction  Handshake      Payload
// in_ch     input      valid / ready  action, left_x, top_y, rect_width, rect_height,
//                                     pixel_color, read_address
// out_ch    output     valid / ready  read_color
//
// Every item gives one result item. The frame store takes one pixel a cycle. Reset is
// synchronous and active low, and a clearing pass over the whole frame store follows it
// with input ready low. A stalled result waits in the output register while later items
// go on in the queue.
module clipped_rectangle_fill_engine #(
  parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  crfe_in_if.sink    in_ch,
  crfe_out_if.source out_ch
);
  import crfe_pkg::*;

  // The front end turns each item into one command, or four for an outline (one per edge).
  // Clipping is done there, so the back end only walks boxes that lie on screen.
  crfe_cmd_t q_push_data;
  logic      q_push_valid;
  logic      q_push_ready;
  crfe_cmd_t q_pop_data;
  logic      q_pop_valid;
  logic      q_pop;
  logic      init_done;

  crfe_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .init_done  (init_done),
    .push_data  (q_push_data),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready)
  );

  // The queue lets the front classify the next item while the back end is still painting.
  crfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (q_push_data),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .pop_data   (q_pop_data),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop)
  );

  // The back end owns the frame store. It runs clears, box walks and reads, and it
  // loads the output register when a command closes an item.
  crfe_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (q_pop_data),
    .pop_valid (q_pop_valid),
    .pop       (q_pop),
    .out_ch    (out_ch),
    .init_done (init_done)
  );

  // No item is taken before the clearing pass after reset has finished.
  a_no_accept_before_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // No result appears before the clearing pass has finished.
  a_no_result_before_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !out_ch.valid)
    else $error("result during clearing pass");

  // The back end only pops a command when the queue holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_pop_valid)
    else $error("pop from empty command queue");

  // A command that goes into the queue leaves it non-empty in the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && q_push_ready |=> q_pop_valid)
    else $error("pushed command lost");

endmodule

### sv/crfe_ram.sv
module crfe_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/crfe_front.sv
module crfe_front #(
  parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  crfe_in_if.sink            in_ch,
  input  logic               init_done,
  output crfe_pkg::crfe_cmd_t push_data,
  output logic               push_valid,
  input  logic               push_ready
);
  import crfe_pkg::*;

  localparam logic signed [EDGE_W-1:0] X_MAX = EDGE_W'(SCREEN_WIDTH - 1);
  localparam logic signed [EDGE_W-1:0] Y_MAX = EDGE_W'(SCREEN_HEIGHT - 1);

  crfe_front_state_t          state_r, state_nxt;
  crfe_action_t               act_r;
  crfe_edge_t                 edge_r;
  logic signed [SCOORD_W-1:0] lx_r, ty_r;
  logic [SPAN_W-1:0]          w_r, h_r;
  logic [COLOR_W-1:0]         color_r;
  logic [RADDR_W-1:0]         addr_r;

  logic                       accept;
  logic                       last;
  logic                       empty;
  logic signed [EDGE_W-1:0]   lx_e, ty_e, rx_e, by_e;
  logic signed [EDGE_W-1:0]   xa, xb, ya, yb;
  logic signed [EDGE_W-1:0]   x0c, x1c, y0c, y1c;

  assign accept = in_ch.valid && in_ch.ready;

  // Rectangle edges and the box for the current command.
  always_comb begin
    lx_e = EDGE_W'(lx_r);
    ty_e = EDGE_W'(ty_r);
    rx_e = lx_e + $signed({2'b00, w_r});
    by_e = ty_e + $signed({2'b00, h_r});
    xa   = lx_e;
    xb   = rx_e;
    ya   = ty_e;
    yb   = by_e;
    if (act_r == ACT_OUTLINE) begin
      case (edge_r)
        EDGE_TOP:    yb = ty_e;
        EDGE_BOTTOM: ya = by_e;
        EDGE_LEFT:   xb = lx_e;
        default:     xa = rx_e;
      endcase
    end
    x0c   = xa[EDGE_W-1] ? '0 : xa;
    x1c   = (xb > X_MAX) ? X_MAX : xb;
    y0c   = ya[EDGE_W-1] ? '0 : ya;
    y1c   = (yb > Y_MAX) ? Y_MAX : yb;
    empty = (x0c > x1c) || (y0c > y1c);
    last  = (act_r != ACT_OUTLINE) || (edge_r == EDGE_RIGHT);
  end

  always_comb begin
    push_data.resp  = last;
    push_data.x0    = x0c[XY_W-1:0];
    push_data.x1    = x1c[XY_W-1:0];
    push_data.y0    = y0c[XY_W-1:0];
    push_data.y1    = y1c[XY_W-1:0];
    push_data.color = color_r;
    push_data.addr  = addr_r;
    unique case (act_r)
      ACT_CLEAR: push_data.kind = CMD_CLEAR;
      ACT_READ:  push_data.kind = CMD_READ;
      default:   push_data.kind = empty ? CMD_NOP : CMD_BOX;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_EMIT;
      F_EMIT: if (push_ready && last) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = (state_r == F_IDLE) && init_done;
    push_valid  = (state_r == F_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= crfe_action_t'(in_ch.action);
      lx_r    <= in_ch.left_x;
      ty_r    <= in_ch.top_y;
      w_r     <= in_ch.rect_width;
      h_r     <= in_ch.rect_height;
      color_r <= in_ch.pixel_color;
      addr_r  <= in_ch.read_address;
      edge_r  <= EDGE_TOP;
    end else if (push_valid && push_ready && !last) begin
      edge_r  <= crfe_edge_t'(edge_r + 2'd1);
    end
  end

endmodule

### sv/crfe_queue.sv
module crfe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  crfe_pkg::crfe_cmd_t push_data,
  input  logic                push_valid,
  output logic                push_ready,
  output crfe_pkg::crfe_cmd_t pop_data,
  output logic                pop_valid,
  input  logic                pop
);
  import crfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  crfe_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/crfe_back.sv
module crfe_back #(
  parameter int SCREEN_WIDTH  = crfe_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = crfe_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crfe_pkg::crfe_cmd_t pop_data,
  input  logic                pop_valid,
  output logic                pop,
  crfe_out_if.source          out_ch,
  output logic                init_done
);
  import crfe_pkg::*;

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crfe_back_state_t   state_r, state_nxt;
  crfe_cmd_t          cmd_r;
  logic               resp_r;
  logic               hit_r;
  logic               init_done_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [ADDR_W-1:0]  cnt_r;
  logic [ADDR_W-1:0]  row_base_r;
  logic [XY_W-1:0]    x_r, y_r;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [COLOR_W-1:0] wdata, rdata;

  logic [ADDR_W-1:0]  box_addr;
  logic [ADDR_W-1:0]  row_start;
  logic               in_range;
  logic               clear_last;
  logic               row_end;
  logic               box_last;
  logic               out_free;

  assign box_addr   = row_base_r + ADDR_W'(x_r);
  assign row_start  = ADDR_W'(32'(pop_data.y0) * 32'(SCREEN_WIDTH));
  assign in_range   = (32'(pop_data.addr) < 32'(DEPTH));
  assign clear_last = (cnt_r == ADDR_W'(DEPTH - 1));
  assign row_end    = (x_r == cmd_r.x1);
  assign box_last   = row_end && (y_r == cmd_r.y1);
  assign out_free   = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          case (pop_data.kind)
            CMD_CLEAR: state_nxt = B_CLEAR;
            CMD_BOX:   state_nxt = B_BOX;
            CMD_READ:  state_nxt = in_range ? B_RDATA : B_DONE;
            default:   state_nxt = pop_data.resp ? B_DONE : B_IDLE;
          endcase
        end
      end
      B_CLEAR: if (clear_last) state_nxt = resp_r ? B_DONE : B_IDLE;
      B_BOX:   if (box_last) state_nxt = resp_r ? B_DONE : B_IDLE;
      B_RDATA: state_nxt = B_DONE;
      B_DONE:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // State outputs: queue pop and frame store port controls.
  always_comb begin
    pop   = (state_r == B_IDLE) && pop_valid;
    we    = (state_r == B_CLEAR) || (state_r == B_BOX);
    waddr = (state_r == B_CLEAR) ? cnt_r : box_addr;
    wdata = (state_r == B_CLEAR) ? '0 : cmd_r.color;
    re    = pop && (pop_data.kind == CMD_READ) && in_range;
    raddr = ADDR_W'(pop_data.addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      resp_r      <= 1'b0;
      cnt_r       <= '0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            cmd_r      <= pop_data;
            resp_r     <= pop_data.resp;
            hit_r      <= in_range;
            cnt_r      <= '0;
            row_base_r <= row_start;
            x_r        <= pop_data.x0;
            y_r        <= pop_data.y0;
          end
        end
        B_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (clear_last) begin
            init_done_r <= 1'b1;
          end
        end
        B_BOX: begin
          if (row_end) begin
            x_r        <= cmd_r.x0;
            y_r        <= y_r + 1'b1;
            row_base_r <= row_base_r + ADDR_W'(SCREEN_WIDTH);
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_color_r <= ((cmd_r.kind == CMD_READ) && hit_r) ? rdata : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  crfe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_color = out_color_r;
  assign init_done         = init_done_r;

endmodule
